// ===== rtl/gne_pkg.sv =====
package gne_pkg;

    localparam int MAX_SIDE_DEF  = 32;
    localparam int MAX_WIRES_DEF = 63;
    localparam int MAX_GATES_DEF = 64;

    localparam int CFG_W   = 6;
    localparam int LABEL_W = 6;
    localparam int POWER_W = 64;
    localparam int COUNT_W = 7;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;
    localparam int               MIN_SIDE   = 5;

    // register select bit of the byte address
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // 3x3 windows, first row in the top bits
    localparam logic [8:0] PAT_LR = 9'b110101110;
    localparam logic [8:0] PAT_RL = 9'b011101011;
    localparam logic [8:0] PAT_TB = 9'b111101010;
    localparam logic [8:0] PAT_BT = 9'b010101111;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_POWER = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        DIR_LR,
        DIR_RL,
        DIR_TB,
        DIR_BT
    } dir_t;

    typedef enum logic [4:0] {
        C_NOP,
        C_LOAD,
        C_POWER,
        C_X_INIT,
        C_CLR,
        C_RD_XY,
        C_SCAN_HIT,
        C_SCAN_NEXT,
        C_POP,
        C_TAKE,
        C_NB_RD,
        C_NB_HIT,
        C_NB_NEXT,
        C_G_INIT,
        C_WIN,
        C_G_MATCH,
        C_G_L2,
        C_G_WR,
        C_T_INIT,
        C_T_RD,
        C_T_CHK,
        C_T_FIN,
        C_EMIT
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_X_INIT,
        S_CLR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_TAKE,
        S_NB_RD,
        S_NB_CHK,
        S_G_INIT,
        S_WIN,
        S_G_MATCH,
        S_G_L2,
        S_G_WR,
        S_T_LOOP,
        S_T_CHK
    } state_t;

    typedef struct packed {
        logic clr_last;
        logic scan_hit;
        logic scan_last;
        logic sp_empty;
        logic k_last;
        logic win_done;
        logic g_go;
        logic g_last;
        logic t_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/gne_dp.sv =====
module gne_dp #(
    parameter int MAX_SIDE  = gne_pkg::MAX_SIDE_DEF,
    parameter int MAX_WIRES = gne_pkg::MAX_WIRES_DEF,
    parameter int MAX_GATES = gne_pkg::MAX_GATES_DEF,
    localparam int EW = $clog2(MAX_SIDE + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gne_pkg::cmd_t                   cmd,
    input  logic [EW-1:0]                   eff_w,
    input  logic [EW-1:0]                   eff_h,
    input  logic                            cell_filled,
    input  logic [gne_pkg::LABEL_W-1:0]     wire_id,
    input  logic                            result_stall,
    output gne_pkg::dp_status_t             status,
    output logic                            result_valid,
    output logic [gne_pkg::POWER_W-1:0]     wire_states,
    output logic [gne_pkg::LABEL_W-1:0]     wire_count,
    output logic [gne_pkg::COUNT_W-1:0]     gate_count,
    output logic                            overflow
);

    localparam int SW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * SW;
    localparam int DEPTH = 1 << AW;
    localparam int PW    = $clog2(MAX_SIDE + 2);
    localparam int GI_W  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int GC_W  = $clog2(MAX_GATES + 1);
    localparam int LW    = gne_pkg::LABEL_W;
    localparam logic [AW:0]   SP_MAX   = (AW+1)'(DEPTH);
    localparam logic [LW-1:0] WIRE_MAX = LW'(MAX_WIRES);
    localparam logic [GC_W-1:0] GATE_MAX = GC_W'(MAX_GATES);

    logic                  cell_mem [DEPTH];
    logic [LW-1:0]         lbl_mem  [DEPTH];
    logic [AW-1:0]         st_mem   [DEPTH];
    logic [2*LW-1:0]       g_mem    [MAX_GATES];

    logic [SW-1:0]   x_reg, y_reg, cx_reg, cy_reg;
    logic [1:0]      k_reg;
    logic [3:0]      cnt_reg;
    logic [8:0]      mask_reg;
    gne_pkg::dir_t   dir_reg;
    logic [AW:0]     sp_reg;
    logic [AW-1:0]   clr_reg;
    logic [LW-1:0]   wires_reg, lab_reg, src_lab_reg;
    logic            lim_reg;
    logic [GC_W-1:0] gates_reg, gidx_reg;
    logic [gne_pkg::POWER_W-1:0] pow_reg, npow_reg;
    logic [PW-1:0]   row_reg, col_reg;

    logic            cell_q, inb_q;
    logic [LW-1:0]   lbl_q;
    logic [AW-1:0]   addr_q, st_q;
    logic [2*LW-1:0] g_q;

    logic [EW-1:0]   wm2, hm2, wm3, hm3;
    logic [SW-1:0]   rx, ry;
    logic [AW-1:0]   rd_addr;
    logic            inb_c;
    logic [1:0]      dx, dy;
    gne_pkg::dir_t   dir_c;
    logic            match_c, full_c, room_c;
    logic [LW-1:0]   new_lab;
    logic            scan_hit_c;
    logic [PW-1:0]   ld_row, ld_col, ld_row_n, ld_col_n;
    logic            ld_we;
    logic [AW-1:0]   ld_addr;
    logic            lbl_we;
    logic [AW-1:0]   lbl_wa;
    logic [LW-1:0]   lbl_wd;
    logic            push;
    logic [AW-1:0]   push_d;

    assign wm2 = eff_w - EW'(2);
    assign hm2 = eff_h - EW'(2);
    assign wm3 = eff_w - EW'(3);
    assign hm3 = eff_h - EW'(3);

    // window offsets, 0 stands for -1
    always_comb
    begin
        unique case (cnt_reg)
            4'd0:    begin dx = 2'd0; dy = 2'd0; end
            4'd1:    begin dx = 2'd1; dy = 2'd0; end
            4'd2:    begin dx = 2'd2; dy = 2'd0; end
            4'd3:    begin dx = 2'd0; dy = 2'd1; end
            4'd4:    begin dx = 2'd1; dy = 2'd1; end
            4'd5:    begin dx = 2'd2; dy = 2'd1; end
            4'd6:    begin dx = 2'd0; dy = 2'd2; end
            4'd7:    begin dx = 2'd1; dy = 2'd2; end
            4'd8:    begin dx = 2'd2; dy = 2'd2; end
            default: begin dx = 2'd1; dy = 2'd1; end
        endcase
    end

    always_comb
    begin
        match_c = 1'b1;
        dir_c   = gne_pkg::DIR_LR;
        priority if (mask_reg == gne_pkg::PAT_LR) dir_c = gne_pkg::DIR_LR;
        else if (mask_reg == gne_pkg::PAT_RL)     dir_c = gne_pkg::DIR_RL;
        else if (mask_reg == gne_pkg::PAT_TB)     dir_c = gne_pkg::DIR_TB;
        else if (mask_reg == gne_pkg::PAT_BT)     dir_c = gne_pkg::DIR_BT;
        else                                      match_c = 1'b0;
    end

    assign full_c = (gates_reg == GATE_MAX);
    assign room_c = (wires_reg < WIRE_MAX);
    assign new_lab = room_c ? wires_reg + LW'(1) : wires_reg;

    // read address for the shared cell / label port
    always_comb
    begin
        rx = x_reg;
        ry = y_reg;
        unique case (cmd)
            gne_pkg::C_NB_RD:
            begin
                rx = cx_reg;
                ry = cy_reg;
                unique case (k_reg)
                    2'd0: rx = cx_reg + SW'(1);
                    2'd1: rx = cx_reg - SW'(1);
                    2'd2: ry = cy_reg + SW'(1);
                    2'd3: ry = cy_reg - SW'(1);
                endcase
            end
            gne_pkg::C_WIN:
            begin
                rx = x_reg + SW'(dx) - SW'(1);
                ry = y_reg + SW'(dy) - SW'(1);
            end
            gne_pkg::C_G_MATCH:
            begin
                unique case (dir_c)
                    gne_pkg::DIR_LR: rx = x_reg - SW'(1);
                    gne_pkg::DIR_RL: rx = x_reg + SW'(1);
                    gne_pkg::DIR_TB: ry = y_reg - SW'(1);
                    gne_pkg::DIR_BT: ry = y_reg + SW'(1);
                endcase
            end
            gne_pkg::C_G_L2:
            begin
                unique case (dir_reg)
                    gne_pkg::DIR_LR: rx = x_reg + SW'(1);
                    gne_pkg::DIR_RL: rx = x_reg - SW'(1);
                    gne_pkg::DIR_TB: ry = y_reg + SW'(1);
                    gne_pkg::DIR_BT: ry = y_reg - SW'(1);
                endcase
            end
            default: ;
        endcase
    end

    assign rd_addr = {ry, rx};
    assign inb_c   = (rx != '0) && (EW'(rx) <= wm2) && (ry != '0) && (EW'(ry) <= hm2);
    assign scan_hit_c = inb_q && cell_q && (lbl_q == '0);

    // load position; a narrowed width can leave the column past the end
    always_comb
    begin
        ld_row = row_reg;
        ld_col = col_reg;
        if (ld_col >= PW'(eff_w))
        begin
            ld_col = '0;
            ld_row = ld_row + PW'(1);
        end
        ld_we    = (ld_row < PW'(eff_h));
        ld_addr  = {ld_row[SW-1:0], ld_col[SW-1:0]};
        ld_row_n = ld_row;
        ld_col_n = ld_col;
        if (ld_we)
        begin
            ld_col_n = ld_col + PW'(1);
            if (ld_col_n >= PW'(eff_w))
            begin
                ld_col_n = '0;
                ld_row_n = ld_row + PW'(1);
            end
        end
    end

    always_comb
    begin
        lbl_we = 1'b0;
        lbl_wa = clr_reg;
        lbl_wd = '0;
        push   = 1'b0;
        push_d = addr_q;
        unique case (cmd)
            gne_pkg::C_CLR:
            begin
                lbl_we = 1'b1;
            end
            gne_pkg::C_SCAN_HIT:
            begin
                lbl_we = 1'b1;
                lbl_wa = {y_reg, x_reg};
                lbl_wd = new_lab;
                push   = 1'b1;
                push_d = {y_reg, x_reg};
            end
            gne_pkg::C_NB_HIT:
            begin
                lbl_we = 1'b1;
                lbl_wa = addr_q;
                lbl_wd = lab_reg;
                push   = 1'b1;
            end
            default: ;
        endcase
    end

    assign status.clr_last  = &clr_reg;
    assign status.scan_hit  = scan_hit_c;
    assign status.scan_last = (EW'(x_reg) == wm2) && (EW'(y_reg) == hm2);
    assign status.sp_empty  = (sp_reg == '0);
    assign status.k_last    = (k_reg == 2'd3);
    assign status.win_done  = (cnt_reg == 4'd9);
    assign status.g_go      = match_c && !full_c;
    assign status.g_last    = (EW'(x_reg) == wm3) && (EW'(y_reg) == hm3);
    assign status.t_done    = (gidx_reg == gates_reg);
    assign status.out_free  = !result_valid || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0; y_reg <= '0; cx_reg <= '0; cy_reg <= '0;
            k_reg <= '0; cnt_reg <= '0; mask_reg <= '0;
            dir_reg <= gne_pkg::DIR_LR;
            sp_reg <= '0; clr_reg <= '0;
            wires_reg <= '0; lab_reg <= '0; src_lab_reg <= '0;
            lim_reg <= 1'b0;
            gates_reg <= '0; gidx_reg <= '0;
            pow_reg <= '0; npow_reg <= '0;
            row_reg <= '0; col_reg <= '0;
        end
        else
        begin
            unique case (cmd)
                gne_pkg::C_LOAD:
                begin
                    row_reg <= ld_row_n;
                    col_reg <= ld_col_n;
                end
                gne_pkg::C_POWER:
                begin
                    if (wire_id <= wires_reg)
                        pow_reg[wire_id] <= 1'b1;
                end
                gne_pkg::C_X_INIT:
                begin
                    row_reg <= '0; col_reg <= '0;
                    pow_reg <= '0; wires_reg <= '0; gates_reg <= '0;
                    lim_reg <= 1'b0; clr_reg <= '0; sp_reg <= '0;
                    x_reg <= SW'(1); y_reg <= SW'(1);
                end
                gne_pkg::C_CLR:
                    clr_reg <= clr_reg + AW'(1);
                gne_pkg::C_SCAN_HIT:
                begin
                    wires_reg <= new_lab;
                    lab_reg   <= new_lab;
                    if (!room_c)
                        lim_reg <= 1'b1;
                    sp_reg <= sp_reg + (AW+1)'(1);
                end
                gne_pkg::C_SCAN_NEXT:
                begin
                    if (EW'(y_reg) == hm2)
                    begin
                        y_reg <= SW'(1);
                        x_reg <= x_reg + SW'(1);
                    end
                    else
                        y_reg <= y_reg + SW'(1);
                end
                gne_pkg::C_POP:
                    sp_reg <= sp_reg - (AW+1)'(1);
                gne_pkg::C_TAKE:
                begin
                    cx_reg <= st_q[SW-1:0];
                    cy_reg <= st_q[AW-1:SW];
                    k_reg  <= '0;
                end
                gne_pkg::C_NB_HIT:
                begin
                    sp_reg <= sp_reg + (AW+1)'(1);
                    k_reg  <= k_reg + 2'd1;
                end
                gne_pkg::C_NB_NEXT:
                    k_reg <= k_reg + 2'd1;
                gne_pkg::C_G_INIT:
                begin
                    x_reg   <= SW'(2);
                    y_reg   <= SW'(2);
                    cnt_reg <= '0;
                end
                gne_pkg::C_WIN:
                begin
                    // data of the previous read arrives from the registered read port
                    if (cnt_reg != '0)
                        mask_reg <= {mask_reg[7:0], inb_q & cell_q};
                    cnt_reg <= cnt_reg + 4'd1;
                end
                gne_pkg::C_G_MATCH:
                begin
                    dir_reg <= dir_c;
                    if (match_c && full_c)
                        lim_reg <= 1'b1;
                    if (!(match_c && !full_c))
                    begin
                        cnt_reg <= '0;
                        if (EW'(x_reg) == wm3)
                        begin
                            x_reg <= SW'(2);
                            y_reg <= y_reg + SW'(1);
                        end
                        else
                            x_reg <= x_reg + SW'(1);
                    end
                end
                gne_pkg::C_G_L2:
                    src_lab_reg <= lbl_q;
                gne_pkg::C_G_WR:
                begin
                    gates_reg <= gates_reg + GC_W'(1);
                    cnt_reg   <= '0;
                    if (EW'(x_reg) == wm3)
                    begin
                        x_reg <= SW'(2);
                        y_reg <= y_reg + SW'(1);
                    end
                    else
                        x_reg <= x_reg + SW'(1);
                end
                gne_pkg::C_T_INIT:
                begin
                    gidx_reg <= '0;
                    npow_reg <= '0;
                end
                gne_pkg::C_T_CHK:
                begin
                    if (!pow_reg[g_q[2*LW-1:LW]])
                        npow_reg[g_q[LW-1:0]] <= 1'b1;
                    gidx_reg <= gidx_reg + GC_W'(1);
                end
                gne_pkg::C_T_FIN:
                    pow_reg <= npow_reg;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid <= 1'b0;
        else if (cmd == gne_pkg::C_EMIT)
            result_valid <= 1'b1;
        else if (!result_stall)
            result_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd == gne_pkg::C_EMIT)
        begin
            wire_states <= pow_reg;
            wire_count  <= wires_reg;
            gate_count  <= gne_pkg::COUNT_W'(gates_reg);
            overflow    <= lim_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == gne_pkg::C_LOAD && ld_we)
            cell_mem[ld_addr] <= cell_filled;
        cell_q <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[lbl_wa] <= lbl_wd;
        lbl_q  <= lbl_mem[rd_addr];
        inb_q  <= inb_c;
        addr_q <= rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            st_mem[sp_reg[AW-1:0]] <= push_d;
        if (cmd == gne_pkg::C_POP)
            st_q <= st_mem[AW'(sp_reg - (AW+1)'(1))];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == gne_pkg::C_G_WR)
            g_mem[gates_reg[GI_W-1:0]] <= {src_lab_reg, lbl_q};
        if (cmd == gne_pkg::C_T_RD)
            g_q <= g_mem[gidx_reg[GI_W-1:0]];
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_MAX)
        else $error("fill stack over depth");

    a_wire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wires_reg <= WIRE_MAX)
        else $error("wire label count over limit");

    a_gate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        gates_reg <= GATE_MAX)
        else $error("gate count over limit");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gne_pkg::C_POP |-> sp_reg != '0)
        else $error("pop from empty fill stack");

endmodule

// ===== rtl/gne_ctrl.sv =====
module gne_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [1:0]           action,
    input  logic                 last_cell,
    input  gne_pkg::dp_status_t  status,
    output logic                 item_stall,
    output gne_pkg::cmd_t        cmd
);

    gne_pkg::state_t state_reg, state_next;
    logic            emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gne_pkg::S_IDLE;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    // emit_reg marks a result waiting for a free output slot
    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        cmd        = gne_pkg::C_NOP;
        item_stall = 1'b1;
        unique case (state_reg)
            gne_pkg::S_IDLE:
            begin
                if (emit_reg)
                begin
                    if (status.out_free)
                    begin
                        cmd       = gne_pkg::C_EMIT;
                        emit_next = 1'b0;
                    end
                end
                else
                begin
                    item_stall = 1'b0;
                    if (item_valid)
                    begin
                        unique case (gne_pkg::action_t'(action))
                            gne_pkg::ACT_LOAD:
                            begin
                                cmd = gne_pkg::C_LOAD;
                                if (last_cell)
                                    state_next = gne_pkg::S_X_INIT;
                            end
                            gne_pkg::ACT_POWER:
                            begin
                                cmd       = gne_pkg::C_POWER;
                                emit_next = 1'b1;
                            end
                            gne_pkg::ACT_TICK:
                            begin
                                cmd        = gne_pkg::C_T_INIT;
                                state_next = gne_pkg::S_T_LOOP;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            gne_pkg::S_X_INIT:
            begin
                cmd        = gne_pkg::C_X_INIT;
                state_next = gne_pkg::S_CLR;
            end
            gne_pkg::S_CLR:
            begin
                cmd = gne_pkg::C_CLR;
                if (status.clr_last)
                    state_next = gne_pkg::S_SCAN_RD;
            end
            gne_pkg::S_SCAN_RD:
            begin
                cmd        = gne_pkg::C_RD_XY;
                state_next = gne_pkg::S_SCAN_CHK;
            end
            gne_pkg::S_SCAN_CHK:
            begin
                if (status.scan_hit)
                begin
                    cmd        = gne_pkg::C_SCAN_HIT;
                    state_next = gne_pkg::S_POP;
                end
                else
                begin
                    cmd        = gne_pkg::C_SCAN_NEXT;
                    state_next = status.scan_last ? gne_pkg::S_G_INIT : gne_pkg::S_SCAN_RD;
                end
            end
            gne_pkg::S_POP:
            begin
                if (status.sp_empty)
                begin
                    cmd        = gne_pkg::C_SCAN_NEXT;
                    state_next = status.scan_last ? gne_pkg::S_G_INIT : gne_pkg::S_SCAN_RD;
                end
                else
                begin
                    cmd        = gne_pkg::C_POP;
                    state_next = gne_pkg::S_TAKE;
                end
            end
            gne_pkg::S_TAKE:
            begin
                cmd        = gne_pkg::C_TAKE;
                state_next = gne_pkg::S_NB_RD;
            end
            gne_pkg::S_NB_RD:
            begin
                cmd        = gne_pkg::C_NB_RD;
                state_next = gne_pkg::S_NB_CHK;
            end
            gne_pkg::S_NB_CHK:
            begin
                cmd        = status.scan_hit ? gne_pkg::C_NB_HIT : gne_pkg::C_NB_NEXT;
                state_next = status.k_last ? gne_pkg::S_POP : gne_pkg::S_NB_RD;
            end
            gne_pkg::S_G_INIT:
            begin
                cmd        = gne_pkg::C_G_INIT;
                state_next = gne_pkg::S_WIN;
            end
            gne_pkg::S_WIN:
            begin
                cmd = gne_pkg::C_WIN;
                if (status.win_done)
                    state_next = gne_pkg::S_G_MATCH;
            end
            gne_pkg::S_G_MATCH:
            begin
                cmd = gne_pkg::C_G_MATCH;
                if (status.g_go)
                    state_next = gne_pkg::S_G_L2;
                else if (status.g_last)
                begin
                    state_next = gne_pkg::S_IDLE;
                    emit_next  = 1'b1;
                end
                else
                    state_next = gne_pkg::S_WIN;
            end
            gne_pkg::S_G_L2:
            begin
                cmd        = gne_pkg::C_G_L2;
                state_next = gne_pkg::S_G_WR;
            end
            gne_pkg::S_G_WR:
            begin
                cmd = gne_pkg::C_G_WR;
                if (status.g_last)
                begin
                    state_next = gne_pkg::S_IDLE;
                    emit_next  = 1'b1;
                end
                else
                    state_next = gne_pkg::S_WIN;
            end
            gne_pkg::S_T_LOOP:
            begin
                if (status.t_done)
                begin
                    cmd        = gne_pkg::C_T_FIN;
                    state_next = gne_pkg::S_IDLE;
                    emit_next  = 1'b1;
                end
                else
                begin
                    cmd        = gne_pkg::C_T_RD;
                    state_next = gne_pkg::S_T_CHK;
                end
            end
            gne_pkg::S_T_CHK:
            begin
                cmd        = gne_pkg::C_T_CHK;
                state_next = gne_pkg::S_T_LOOP;
            end
            default:
                state_next = gne_pkg::S_IDLE;
        endcase
    end

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == gne_pkg::C_EMIT |-> state_reg == gne_pkg::S_IDLE && emit_reg)
        else $error("result emitted outside idle");

    a_no_take_pending: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> item_stall)
        else $error("item taken while result pending");

    a_clear_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == gne_pkg::S_X_INIT |=> state_reg == gne_pkg::S_CLR)
        else $error("extraction skipped label clear");

endmodule

// ===== rtl/grid_netlist_extract_and_simulate.sv =====
// load beat: no result; power beat: result once the output slot is free
// last cell: label clear over the whole label memory, scan of the interior cells,
//   flood fill of each wire, then a 3x3 window check at each gate position
// tick: one stored gate at a time, set by the single-port gate table walk
// one item at a time; no item taken while a finished result waits for a free output slot
// rst_n async low: clears control, counts and wire power; grid size resets to 32x32
module grid_netlist_extract_and_simulate #(
    parameter int MAX_SIDE  = gne_pkg::MAX_SIDE_DEF,
    parameter int MAX_WIRES = gne_pkg::MAX_WIRES_DEF,
    parameter int MAX_GATES = gne_pkg::MAX_GATES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gne_pkg::ADDR_W-1:0]       paddr,
    input  logic [gne_pkg::DATA_W-1:0]       pwdata,
    output logic [gne_pkg::DATA_W-1:0]       prdata,
    output logic                             pready,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  logic [1:0]                       action,
    input  logic                             cell_filled,
    input  logic                             last_cell,
    input  logic [gne_pkg::LABEL_W-1:0]      wire_id,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [gne_pkg::POWER_W-1:0]      wire_states,
    output logic [gne_pkg::LABEL_W-1:0]      wire_count,
    output logic [gne_pkg::COUNT_W-1:0]      gate_count,
    output logic                             overflow
);

    localparam int EW = $clog2(MAX_SIDE + 1);
    localparam int CW = gne_pkg::CFG_W + 2;

    logic [gne_pkg::CFG_W-1:0] grid_width_reg, grid_height_reg;
    logic [EW-1:0]             eff_w, eff_h;
    gne_pkg::cmd_t             cmd;
    gne_pkg::dp_status_t       status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= gne_pkg::GRID_RESET;
            grid_height_reg <= gne_pkg::GRID_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                gne_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[gne_pkg::CFG_W-1:0];
                gne_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[gne_pkg::CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            gne_pkg::REG_GRID_WIDTH:  prdata[gne_pkg::CFG_W-1:0] = grid_width_reg;
            gne_pkg::REG_GRID_HEIGHT: prdata[gne_pkg::CFG_W-1:0] = grid_height_reg;
        endcase
    end

    // sides in use are clamped to the supported range
    always_comb
    begin
        priority if (CW'(grid_width_reg) < CW'(gne_pkg::MIN_SIDE))
            eff_w = EW'(gne_pkg::MIN_SIDE);
        else if (CW'(grid_width_reg) > CW'(MAX_SIDE))
            eff_w = EW'(MAX_SIDE);
        else
            eff_w = EW'(grid_width_reg);
        priority if (CW'(grid_height_reg) < CW'(gne_pkg::MIN_SIDE))
            eff_h = EW'(gne_pkg::MIN_SIDE);
        else if (CW'(grid_height_reg) > CW'(MAX_SIDE))
            eff_h = EW'(MAX_SIDE);
        else
            eff_h = EW'(grid_height_reg);
    end

    gne_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .action     (action),
        .last_cell  (last_cell),
        .status     (status),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    gne_dp #(
        .MAX_SIDE  (MAX_SIDE),
        .MAX_WIRES (MAX_WIRES),
        .MAX_GATES (MAX_GATES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .cell_filled  (cell_filled),
        .wire_id      (wire_id),
        .result_stall (result_stall),
        .status       (status),
        .result_valid (result_valid),
        .wire_states  (wire_states),
        .wire_count   (wire_count),
        .gate_count   (gate_count),
        .overflow     (overflow)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SIDE = 32;

    typedef struct {
        gne_pkg::action_t act;
        logic             filled;
        logic             last;
        logic [5:0]       id;
    } beat_t;

    typedef struct {
        logic [63:0] states;
        logic [5:0]  wires;
        logic [6:0]  gates;
        logic        ovf;
    } snapshot_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [gne_pkg::ADDR_W-1:0] paddr = '0;
    logic [gne_pkg::DATA_W-1:0] pwdata = '0;
    logic [gne_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] action = gne_pkg::ACT_LOAD;
    logic cell_filled = 1'b0, last_cell = 1'b0;
    logic [gne_pkg::LABEL_W-1:0] wire_id = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [gne_pkg::POWER_W-1:0] wire_states;
    logic [gne_pkg::LABEL_W-1:0] wire_count;
    logic [gne_pkg::COUNT_W-1:0] gate_count;
    logic overflow;

    grid_netlist_extract_and_simulate DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall),
        .action(action), .cell_filled(cell_filled), .last_cell(last_cell),
        .wire_id(wire_id),
        .result_valid(result_valid), .result_stall(result_stall),
        .wire_states(wire_states), .wire_count(wire_count),
        .gate_count(gate_count), .overflow(overflow)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    beat_t     pending[$];
    snapshot_t expected_results[$];
    beat_t     cur;
    bit        took = 1'b0;
    int        send_idle = 0, stall_pct = 0;
    int        errors = 0, cycles = 0, results_seen = 0, beats_sent = 0;

    // shadow of the block
    int          cfg_w = 32, cfg_h = 32;
    bit          grid_cells [SIDE][SIDE];
    logic [5:0]  wire_label [SIDE][SIDE];
    logic [5:0]  gate_from [64];
    logic [5:0]  gate_to [64];
    logic [63:0] powered = '0;
    int          n_wires = 0, n_gates = 0;
    bit          limit_flag = 0;
    int          ld_row = 0, ld_col = 0;
    int          fill_stack [SIDE*SIDE];

    function automatic int clamp_side(int v);
        if (v < gne_pkg::MIN_SIDE) return gne_pkg::MIN_SIDE;
        if (v > SIDE) return SIDE;
        return v;
    endfunction

    function automatic bit conducts(int x, int y, int w, int h);
        if (x < 1 || x > w - 2 || y < 1 || y > h - 2) return 0;
        return grid_cells[y][x];
    endfunction

    function automatic void record_gate(logic [5:0] src, logic [5:0] dst);
        if (n_gates < 64)
        begin
            gate_from[n_gates] = src;
            gate_to[n_gates] = dst;
            n_gates++;
        end
        else
            limit_flag = 1;
    endfunction

    function automatic void extract_netlist();
        int w, h, sp, p, cx, cy, nx, ny, k;
        logic [8:0] win;
        int dx[4], dy[4];
        w = clamp_side(cfg_w);
        h = clamp_side(cfg_h);
        dx = '{1, -1, 0, 0};
        dy = '{0, 0, 1, -1};
        foreach (wire_label[a, b]) wire_label[a][b] = '0;
        powered = '0;
        n_wires = 0;
        n_gates = 0;
        limit_flag = 0;
        for (int x = 1; x < w - 1; x++)
            for (int y = 1; y < h - 1; y++)
                if (conducts(x, y, w, h) && wire_label[y][x] == 0)
                begin
                    if (n_wires < 63) n_wires++;
                    else limit_flag = 1;
                    wire_label[y][x] = n_wires[5:0];
                    sp = 0;
                    fill_stack[sp++] = y * SIDE + x;
                    while (sp > 0)
                    begin
                        p = fill_stack[--sp];
                        cx = p % SIDE;
                        cy = p / SIDE;
                        for (k = 0; k < 4; k++)
                        begin
                            nx = cx + dx[k];
                            ny = cy + dy[k];
                            if (conducts(nx, ny, w, h) && wire_label[ny][nx] == 0)
                            begin
                                wire_label[ny][nx] = n_wires[5:0];
                                fill_stack[sp++] = ny * SIDE + nx;
                            end
                        end
                    end
                end
        for (int y = 2; y < h - 2; y++)
            for (int x = 2; x < w - 2; x++)
            begin
                win = '0;
                for (int j = -1; j <= 1; j++)
                    for (int i = -1; i <= 1; i++)
                        win[8 - 3 * (j + 1) - (i + 1)] = conducts(x + i, y + j, w, h);
                if (win == gne_pkg::PAT_LR)
                    record_gate(wire_label[y][x-1], wire_label[y][x+1]);
                else if (win == gne_pkg::PAT_RL)
                    record_gate(wire_label[y][x+1], wire_label[y][x-1]);
                else if (win == gne_pkg::PAT_TB)
                    record_gate(wire_label[y-1][x], wire_label[y+1][x]);
                else if (win == gne_pkg::PAT_BT)
                    record_gate(wire_label[y+1][x], wire_label[y-1][x]);
            end
    endfunction

    function automatic void predict_beat(beat_t b);
        int w, h;
        logic [63:0] nxt;
        snapshot_t s;
        case (b.act)
            gne_pkg::ACT_LOAD:
            begin
                w = clamp_side(cfg_w);
                h = clamp_side(cfg_h);
                if (ld_col >= w)
                begin
                    ld_col = 0;
                    ld_row++;
                end
                if (ld_row < h)
                begin
                    grid_cells[ld_row][ld_col] = b.filled;
                    ld_col++;
                    if (ld_col >= w)
                    begin
                        ld_col = 0;
                        ld_row++;
                    end
                end
                if (!b.last) return;
                extract_netlist();
                ld_row = 0;
                ld_col = 0;
            end
            gne_pkg::ACT_POWER:
                if (b.id <= n_wires) powered[b.id] = 1'b1;
            gne_pkg::ACT_TICK:
            begin
                nxt = '0;
                for (int g = 0; g < n_gates; g++)
                    if (!powered[gate_from[g]]) nxt[gate_to[g]] = 1'b1;
                powered = nxt;
            end
            default: return;
        endcase
        s.states = powered;
        s.wires = n_wires[5:0];
        s.gates = n_gates[6:0];
        s.ovf = limit_flag;
        expected_results.insert(expected_results.size(), s);
    endfunction

    // driver
    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
        if (rst_n && (!item_valid || took))
        begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                cur = pending.pop_front();
                action <= cur.act;
                cell_filled <= cur.filled;
                last_cell <= cur.last;
                wire_id <= cur.id;
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // input accept and result monitor
    always @(posedge clk)
    begin
        snapshot_t e;
        took = item_valid && !item_stall;
        if (took)
        begin
            predict_beat(cur);
            beats_sent++;
        end
        if (result_valid && !result_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (wire_states !== e.states)
                begin
                    $error("wire_states exp %h got %h", e.states, wire_states);
                    errors++;
                end
                if (wire_count !== e.wires)
                begin
                    $error("wire_count exp %0d got %0d", e.wires, wire_count);
                    errors++;
                end
                if (gate_count !== e.gates)
                begin
                    $error("gate_count exp %0d got %0d", e.gates, gate_count);
                    errors++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow exp %0d got %0d", e.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void queue_op(gne_pkg::action_t a, logic f, logic l, logic [5:0] id);
        beat_t b;
        b.act = a;
        b.filled = f;
        b.last = l;
        b.id = id;
        pending.insert(pending.size(), b);
    endfunction

    // kind: 0 random, 1 isolated dots, 2 dense inverter tiling
    task automatic queue_grid(int w, int h, int kind, int extra, int cut);
        bit img [SIDE][SIDE];
        int dens, cx, cy, n, total;
        logic [8:0] pat;
        dens = $urandom_range(25, 65);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                case (kind)
                    1: img[y][x] = (x % 2 == 1) && (y % 2 == 1);
                    2: img[y][x] = 0;
                    default: img[y][x] = ($urandom_range(99) < dens);
                endcase
        if (kind == 2)
        begin
            for (cy = 2; cy <= h - 3; cy += 3)
                for (cx = 2; cx <= w - 3; cx += 3)
                    for (int k = 0; k < 9; k++)
                        img[cy - 1 + k / 3][cx - 1 + k % 3] = gne_pkg::PAT_LR[8 - k];
        end
        else if (kind == 0)
        begin
            n = $urandom_range(0, 4);
            repeat (n)
            begin
                cx = $urandom_range(2, w - 3);
                cy = $urandom_range(2, h - 3);
                case ($urandom_range(3))
                    0: pat = gne_pkg::PAT_LR;
                    1: pat = gne_pkg::PAT_RL;
                    2: pat = gne_pkg::PAT_TB;
                    default: pat = gne_pkg::PAT_BT;
                endcase
                for (int k = 0; k < 9; k++)
                    img[cy - 1 + k / 3][cx - 1 + k % 3] = pat[8 - k];
            end
        end
        total = (cut > 0) ? cut : w * h;
        for (int i = 0; i < total; i++)
            queue_op(gne_pkg::ACT_LOAD, img[i / w][i % w], (i == total - 1) && extra == 0, '0);
        for (int i = 0; i < extra; i++)
            queue_op(gne_pkg::ACT_LOAD, 1'($urandom_range(1)), i == extra - 1, '0);
    endtask

    task automatic queue_ops(int n);
        repeat (n)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    queue_op(gne_pkg::ACT_POWER, 1'($urandom_range(1)),
                             1'($urandom_range(1)),
                             6'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                         : $urandom_range(12)));
                4, 5, 6, 7, 8:
                    queue_op(gne_pkg::ACT_TICK, 1'($urandom_range(1)),
                             1'($urandom_range(1)), 6'($urandom_range(63)));
                default:
                    queue_op(gne_pkg::ACT_NONE, 1'($urandom_range(1)),
                             1'($urandom_range(1)), 6'($urandom_range(63)));
            endcase
        end
    endtask

    task automatic drain();
        while (pending.size() > 0 || item_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(logic sel, int value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == gne_pkg::REG_GRID_WIDTH) cfg_w = value & 63;
        else cfg_h = value & 63;
    endtask

    task automatic set_grid(int w, int h);
        reg_write(gne_pkg::REG_GRID_WIDTH, w);
        reg_write(gne_pkg::REG_GRID_HEIGHT, h);
    endtask

    int modes_send[4] = '{0, 76, 0, 20};
    int modes_stall[4] = '{0, 0, 76, 20};
    int w, h;

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one tiled inverter, then power and ticks over it
        set_grid(7, 7);
        queue_grid(7, 7, 2, 0, 0);
        queue_op(gne_pkg::ACT_POWER, 1'b0, 1'b0, 6'd1);
        queue_op(gne_pkg::ACT_TICK, 1'b0, 1'b0, 6'd0);
        queue_op(gne_pkg::ACT_TICK, 1'b0, 1'b0, 6'd0);
        queue_op(gne_pkg::ACT_POWER, 1'b1, 1'b1, 6'd63);
        queue_op(gne_pkg::ACT_NONE, 1'b1, 1'b1, 6'd63);
        drain();
        // sizes below the minimum clamp to 5x5; extra cells, then a short reload
        set_grid(3, 4);
        queue_grid(5, 5, 0, 3, 0);
        queue_op(gne_pkg::ACT_POWER, 1'b0, 1'b0, 6'd0);
        queue_op(gne_pkg::ACT_TICK, 1'b0, 1'b0, 6'd0);
        queue_grid(5, 5, 0, 0, 10);
        queue_op(gne_pkg::ACT_TICK, 1'b0, 1'b0, 6'd0);
        drain();

        for (int m = 0; m < 4; m++)
        begin
            send_idle = modes_send[m];
            stall_pct = modes_stall[m];
            w = $urandom_range(5, 7);
            h = $urandom_range(5, 7);
            set_grid(w, h);
            queue_grid(w, h, 0, ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0, 0);
            queue_ops(12);
            drain();
        end

        $display("covered %0d input beats and %0d result beats over grids 5x5 to 7x7,",
                 beats_sent, results_seen);
        $display("with clamped sizes, short reloads, extra cells and four idle/stall mixes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/gne_pkg.sv
rtl/gne_dp.sv
rtl/gne_ctrl.sv
rtl/grid_netlist_extract_and_simulate.sv
tb/sv/testbench.sv
